/* src/rfr_pkg.sv */
`default_nettype none

package rfr_pkg;

  // Default storage shape.
  localparam int DEPTH_DEF     = 256;
  localparam int ITEM_BITS_DEF = 32;

  // Fixed field widths of the channels.
  localparam int ACT_W   = 3;
  localparam int DATA_W  = 32;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  // Capacity register value after reset.
  localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TAKE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESERVE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_COMMIT  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] item_data;
    logic              overwrite_when_full;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  read_data;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] stored_count;
    logic [COUNT_W-1:0] taken_count;
    logic               reservation_open;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic rem_start;
    logic mem_rd;
    logic exec;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_take;
    logic rem_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/rfr_rem.sv */
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module rfr_rem
  import rfr_pkg::*;
#(
  parameter int NW = 10,
  parameter int DW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_r;
  logic [DW-1:0] d_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // Shift in the next dividend bit and subtract when it fits.
  assign trial = {rem_r, n_r[NW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath of the unit carries no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_r <= diff[DW-1:0];
      end else begin
        rem_r <= trial[DW-1:0];
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

/* src/rfr_ctrl.sv */
`default_nettype none

// Sequencer: accept, dispatch, optional slot remainder and read, execute.
module rfr_ctrl
  import rfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MOD,
    ST_READ,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  // Commands decoded from the present state.
  always_comb begin
    cmd.latch_in  = in_valid && in_ready_r;
    cmd.rem_start = (state_r == ST_DISPATCH) && status.is_take;
    cmd.mem_rd    = ((state_r == ST_DISPATCH) && !status.is_take) || (state_r == ST_READ);
    cmd.exec      = (state_r == ST_EXEC) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            in_ready_r <= 1'b0;
            state_r    <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (status.is_take) begin
            state_r <= ST_MOD;
          end else begin
            state_r <= ST_EXEC;
          end
        end
        ST_MOD: begin
          if (status.rem_done) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (status.out_free) begin
            in_ready_r <= 1'b1;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          in_ready_r <= 1'b1;
          state_r    <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

/* src/rfr_dp.sv */
`default_nettype none

// Pointers, counters, item memory and the result register.
module rfr_dp
  import rfr_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ITEM_BITS = ITEM_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire in_item_t           in_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [COUNT_W-1:0] cfg_wr_data,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Latched transaction.
  logic [ACT_W-1:0]  act_r;
  logic [DATA_W-1:0] data_r;
  logic              force_r;

  // Ring state.
  logic [COUNT_W-1:0] cap_r;
  logic [PTR_W-1:0]   rp_r;
  logic [PTR_W-1:0]   wp_r;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   taken_r;
  logic               resv_r;

  logic [ITEM_BITS-1:0] mem_r [DEPTH];
  logic [ITEM_BITS-1:0] rdata_r;

  out_item_t out_r;
  logic      out_valid_r;

  logic [31:0]            cap_ext;
  logic [CNT_W-1:0]       cap_eff;
  logic                   full;
  logic [CNT_W:0]         take_sum;
  logic                   rem_done;
  logic [CNT_W-1:0]       rem;
  logic [PTR_W-1:0]       take_slot;
  logic [PTR_W-1:0]       rd_addr;
  logic [ITEM_BITS+31:0]  wdata_ext;
  logic [ITEM_BITS-1:0]   wdata;
  logic [ITEM_BITS+31:0]  rdata_ext;
  logic [PTR_W-1:0]       rp_bump;
  logic [PTR_W-1:0]       wp_bump;
  logic [CNT_W-1:0]       taken_dec;

  logic                   ok;
  logic                   give_data;
  logic [PTR_W-1:0]       slot;
  logic [PTR_W-1:0]       rp_nxt;
  logic [PTR_W-1:0]       wp_nxt;
  logic [CNT_W-1:0]       fill_nxt;
  logic [CNT_W-1:0]       taken_nxt;
  logic                   resv_nxt;
  logic                   we;
  logic [PTR_W+SLOT_W-1:0]  slot_ext;
  logic [CNT_W+COUNT_W-1:0] fill_ext;
  logic [CNT_W+COUNT_W-1:0] taken_ext;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                            input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= c) ? '0 : PTR_W'(n);
  endfunction

  // Capacity clamped to 1..DEPTH.
  assign cap_ext = 32'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign full      = fill_r >= cap_eff;
  assign rp_bump   = bump(rp_r, cap_eff);
  assign wp_bump   = bump(wp_r, cap_eff);
  assign taken_dec = (taken_r != '0) ? taken_r - CNT_W'(1) : taken_r;

  // Slot of the next untaken item, modulo the capacity.
  assign take_sum = (CNT_W+1)'(rp_r) + (CNT_W+1)'(taken_r);

  rfr_rem #(
    .NW(CNT_W + 1),
    .DW(CNT_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_start),
    .dividend (take_sum),
    .divisor  (cap_eff),
    .done     (rem_done),
    .remainder(rem)
  );

  assign take_slot = PTR_W'(rem);
  assign rd_addr   = (act_r == ACT_TAKE) ? take_slot : rp_r;

  assign wdata_ext = (ITEM_BITS+32)'(data_r);
  assign wdata     = wdata_ext[ITEM_BITS-1:0];
  assign rdata_ext = (ITEM_BITS+32)'(rdata_r);

  // Effect of the latched action on the ring state.
  always_comb begin
    ok        = 1'b0;
    give_data = 1'b0;
    slot      = '0;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    taken_nxt = taken_r;
    resv_nxt  = resv_r;
    we        = 1'b0;
    case (act_r)
      ACT_PUSH: begin
        if (!resv_r && (!full || force_r)) begin
          ok     = 1'b1;
          we     = 1'b1;
          slot   = wp_r;
          wp_nxt = wp_bump;
          if (full) begin
            rp_nxt    = rp_bump;
            taken_nxt = taken_dec;
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
      end
      ACT_POP: begin
        if (fill_r != '0) begin
          ok        = 1'b1;
          give_data = 1'b1;
          slot      = rp_r;
          rp_nxt    = rp_bump;
          fill_nxt  = fill_r - CNT_W'(1);
          taken_nxt = taken_dec;
        end
      end
      ACT_TAKE: begin
        if (taken_r < fill_r) begin
          ok        = 1'b1;
          give_data = 1'b1;
          slot      = take_slot;
          taken_nxt = taken_r + CNT_W'(1);
        end
      end
      ACT_RELEASE: begin
        if (taken_r != '0 && fill_r != '0) begin
          ok        = 1'b1;
          rp_nxt    = rp_bump;
          fill_nxt  = fill_r - CNT_W'(1);
          taken_nxt = taken_r - CNT_W'(1);
        end
      end
      ACT_RESERVE: begin
        if (!resv_r && (!full || force_r)) begin
          ok       = 1'b1;
          slot     = wp_r;
          resv_nxt = 1'b1;
          if (full) begin
            rp_nxt    = rp_bump;
            taken_nxt = taken_dec;
            fill_nxt  = fill_r - CNT_W'(1);
          end
        end
      end
      ACT_COMMIT: begin
        if (resv_r) begin
          ok       = 1'b1;
          we       = 1'b1;
          wp_nxt   = wp_bump;
          resv_nxt = 1'b0;
          if (full) begin
            rp_nxt    = rp_bump;
            taken_nxt = taken_dec;
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
      end
      ACT_CLEAR: begin
        ok        = 1'b1;
        rp_nxt    = '0;
        wp_nxt    = '0;
        fill_nxt  = '0;
        taken_nxt = '0;
        resv_nxt  = 1'b0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign slot_ext  = (PTR_W+SLOT_W)'(slot);
  assign fill_ext  = (CNT_W+COUNT_W)'(fill_nxt);
  assign taken_ext = (CNT_W+COUNT_W)'(taken_nxt);

  // Control state: configuration, pointers, counters, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      rp_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      taken_r     <= '0;
      resv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        rp_r        <= rp_nxt;
        wp_r        <= wp_nxt;
        fill_r      <= fill_nxt;
        taken_r     <= taken_nxt;
        resv_r      <= resv_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction latch, memory port and result payload.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r   <= in_item.action;
      data_r  <= in_item.item_data;
      force_r <= in_item.overwrite_when_full;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem_r[rd_addr];
    end
    if (cmd.exec && we) begin
      mem_r[wp_r] <= wdata;
    end
    if (cmd.exec) begin
      out_r.ok               <= ok;
      out_r.read_data        <= give_data ? rdata_ext[DATA_W-1:0] : '0;
      out_r.slot_index       <= slot_ext[SLOT_W-1:0];
      out_r.stored_count     <= fill_ext[COUNT_W-1:0];
      out_r.taken_count      <= taken_ext[COUNT_W-1:0];
      out_r.reservation_open <= resv_nxt;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.is_take  = act_r == ACT_TAKE;
    status.rem_done = rem_done;
    status.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

/* src/ring_fifo_with_take_and_reserve_top.sv */
`default_nettype none

// Channel   Ports                          Moves
// --------  -----------------------------  -----------------------------------
// input     in_valid, in_ready, in_item    one action transaction
// result    out_valid, out_ready, out_item one result transaction per action
// config    cfg_wr_en, cfg_wr_data         capacity register write
//
// One transaction is in flight at a time. Push, pop, release, reserve, commit
// and clear pass from acceptance to the next acceptance through dispatch
// with the memory read, then execute. Take runs the slot remainder unit over
// $clog2(DEPTH+1)+1 bits, one per cycle, then reads the slot and executes.
// Execute waits while the result register holds an untaken result. Reset is
// synchronous; it clears pointers, counts and the reservation, capacity 256.
module ring_fifo_with_take_and_reserve_top
  import rfr_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ITEM_BITS = ITEM_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [COUNT_W-1:0] cfg_wr_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  rfr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // Ring storage and arithmetic.
  rfr_dp #(
    .DEPTH    (DEPTH),
    .ITEM_BITS(ITEM_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

/* sim/tb.sv */
module tb;
  import rfr_pkg::*;

  // Action code that the block does not define; it must be refused.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  localparam int PHASES         = 16;
  localparam int FILL_PHASE_LEN = 330;
  localparam int PHASE_LEN      = 65;
  localparam int CALM_AFTER     = 1180;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    in_item_t           item;
    logic [COUNT_W-1:0] cap;
    logic               has_exp;
    out_item_t          exp;
  } stim_row_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  in_item_t           in_item     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  out_item_t          out_item;
  logic               cfg_wr_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;

  // Shadow copy of the FIFO state.
  logic [DATA_W-1:0]  fifo_mem [DEPTH_DEF];
  bit                 fifo_mem_set [DEPTH_DEF];
  int                 fifo_rd    = 0;
  int                 fifo_wr    = 0;
  int                 fifo_fill  = 0;
  int                 fifo_taken = 0;
  logic               fifo_resv  = 1'b0;
  logic [COUNT_W-1:0] fifo_cap   = CAP_RESET;

  // Results still owed by the block, oldest first.
  out_item_t fifo_results_q[$];
  stim_row_t directed_rows[$];

  int   errors          = 0;
  int   items_sent      = 0;
  int   results_checked = 0;
  int   full_hits       = 0;
  int   refusals        = 0;
  int   cap_writes      = 0;
  int   gap_pct         = 0;
  int   stall_pct       = 0;
  logic calm            = 1'b0;
  int   idle_cycles     = 0;
  int   ready_left      = 0;

  ring_fifo_with_take_and_reserve_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Capacity as the block uses it: zero acts as one, oversize as the depth.
  function automatic int eff_cap();
    if (fifo_cap == 0) return 1;
    if (fifo_cap > DEPTH_DEF) return DEPTH_DEF;
    return int'(fifo_cap);
  endfunction

  function automatic int step_ptr(input int p, input int cap);
    return (p + 1 >= cap) ? 0 : p + 1;
  endfunction

  task automatic drop_oldest(input int cap);
    fifo_rd = step_ptr(fifo_rd, cap);
    if (fifo_taken > 0) fifo_taken--;
  endtask

  // Apply one action to the shadow state and work out its result.
  task automatic apply_fifo_action(input in_item_t it, output out_item_t r);
    int   cap;
    logic full;
    cap  = eff_cap();
    full = (fifo_fill >= cap);
    r    = '0;
    case (it.action)
      ACT_PUSH: begin
        if (!fifo_resv && (!full || it.overwrite_when_full)) begin
          fifo_mem[fifo_wr]     = it.item_data;
          fifo_mem_set[fifo_wr] = 1'b1;
          r.slot_index          = SLOT_W'(fifo_wr);
          fifo_wr               = step_ptr(fifo_wr, cap);
          if (full) drop_oldest(cap);
          else fifo_fill++;
          r.ok = 1'b1;
        end
      end
      ACT_POP: begin
        if (fifo_fill != 0) begin
          r.read_data  = fifo_mem[fifo_rd];
          r.slot_index = SLOT_W'(fifo_rd);
          fifo_rd      = step_ptr(fifo_rd, cap);
          fifo_fill--;
          if (fifo_taken > 0) fifo_taken--;
          r.ok = 1'b1;
        end
      end
      ACT_TAKE: begin
        if (fifo_taken < fifo_fill) begin
          r.slot_index = SLOT_W'((fifo_rd + fifo_taken) % cap);
          r.read_data  = fifo_mem[(fifo_rd + fifo_taken) % cap];
          fifo_taken++;
          r.ok = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (fifo_taken != 0 && fifo_fill != 0) begin
          fifo_rd = step_ptr(fifo_rd, cap);
          fifo_fill--;
          fifo_taken--;
          r.ok = 1'b1;
        end
      end
      ACT_RESERVE: begin
        if (!fifo_resv && (!full || it.overwrite_when_full)) begin
          r.slot_index = SLOT_W'(fifo_wr);
          if (full) begin
            drop_oldest(cap);
            fifo_fill--;
          end
          fifo_resv = 1'b1;
          r.ok      = 1'b1;
        end
      end
      ACT_COMMIT: begin
        if (fifo_resv) begin
          fifo_mem[fifo_wr]     = it.item_data;
          fifo_mem_set[fifo_wr] = 1'b1;
          fifo_wr               = step_ptr(fifo_wr, cap);
          if (full) drop_oldest(cap);
          else fifo_fill++;
          fifo_resv = 1'b0;
          r.ok      = 1'b1;
        end
      end
      ACT_CLEAR: begin
        fifo_rd    = 0;
        fifo_wr    = 0;
        fifo_fill  = 0;
        fifo_taken = 0;
        fifo_resv  = 1'b0;
        r.ok       = 1'b1;
      end
      default: ;
    endcase
    r.stored_count     = COUNT_W'(fifo_fill);
    r.taken_count      = COUNT_W'(fifo_taken);
    r.reservation_open = fifo_resv;
    if (full && r.ok && (it.action == ACT_PUSH || it.action == ACT_RESERVE ||
                         it.action == ACT_COMMIT)) full_hits++;
    if (!r.ok) refusals++;
  endtask

  // Random action, biased toward pushes by push_w percent and toward
  // closing an open reservation. Reads of never-written slots are avoided.
  function automatic in_item_t random_action(input int push_w);
    in_item_t it;
    int       roll;
    it.item_data           = $urandom;
    it.overwrite_when_full = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (fifo_resv && roll < 60) begin
      it.action = ACT_COMMIT;
    end else if (roll < push_w) begin
      it.action = ACT_PUSH;
    end else begin
      roll = $urandom_range(99);
      if (roll < 25) it.action = ACT_POP;
      else if (roll < 50) it.action = ACT_TAKE;
      else if (roll < 72) it.action = ACT_RELEASE;
      else if (roll < 88) it.action = ACT_RESERVE;
      else if (roll < 94) it.action = ACT_COMMIT;
      else if (roll < 97) it.action = ACT_CLEAR;
      else it.action = ACT_UNUSED;
    end
    if (it.action == ACT_POP && fifo_fill > 0 && !fifo_mem_set[fifo_rd])
      it.action = ACT_PUSH;
    if (it.action == ACT_TAKE && fifo_taken < fifo_fill &&
        !fifo_mem_set[(fifo_rd + fifo_taken) % eff_cap()])
      it.action = ACT_PUSH;
    return it;
  endfunction

  function automatic void row_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] data,
                                   input logic ow, input logic has_exp, input out_item_t exp);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_ITEM;
    row.item    = '{act, data, ow};
    row.has_exp = has_exp;
    row.exp     = exp;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_cap(input logic [COUNT_W-1:0] value);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CAP;
    row.cap  = value;
    directed_rows.push_back(row);
  endfunction

  // Present one transaction, wait for its acceptance and record the result it owes.
  task automatic send_item(input in_item_t it, input logic has_exp, input out_item_t typed);
    out_item_t predicted;
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_fifo_action(it, predicted);
    fifo_results_q.push_back(has_exp ? typed : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // Capacity is only written once every owed result has come back.
  task automatic write_capacity(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (fifo_results_q.size() != 0) @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fifo_cap = value;
    cap_writes++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side stalls in bursts of random length, never in the calm tail.
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left == 0) begin
      ready_left = $urandom_range(1, 16);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end else begin
      ready_left = ready_left - 1;
    end
  end

  // Compare each result transaction with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (fifo_results_q.size() == 0) begin
        $display("%0t: result with nothing owed, actual %h", $time, out_item);
        errors++;
      end else begin
        out_item_t want;
        want = fifo_results_q.pop_front();
        check_field("ok", DATA_W'(want.ok), DATA_W'(out_item.ok));
        check_field("read_data", want.read_data, out_item.read_data);
        check_field("slot_index", DATA_W'(want.slot_index), DATA_W'(out_item.slot_index));
        check_field("stored_count", DATA_W'(want.stored_count),
                    DATA_W'(out_item.stored_count));
        check_field("taken_count", DATA_W'(want.taken_count),
                    DATA_W'(out_item.taken_count));
        check_field("reservation_open", DATA_W'(want.reservation_open),
                    DATA_W'(out_item.reservation_open));
        results_checked++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [COUNT_W-1:0] next_cap;
    int                 push_w;
    int                 phase_len;
    int                 directed_items;

    // Directed table. Rows with a typed result can be read off at a glance.
    row_item(ACT_POP, 32'h0, 1'b0, 1'b1, '0);
    row_item(ACT_RELEASE, 32'h0, 1'b0, 1'b1, '0);
    row_item(ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, '0);
    row_item(ACT_COMMIT, 32'hFFFF_FFFF, 1'b0, 1'b1, '0);
    row_item(ACT_PUSH, 32'hFFFF_FFFF, 1'b0, 1'b1,
             out_item_t'{1'b1, 32'h0, 8'd0, 9'd1, 9'd0, 1'b0});
    row_item(ACT_PUSH, 32'h0, 1'b1, 1'b1,
             out_item_t'{1'b1, 32'h0, 8'd1, 9'd2, 9'd0, 1'b0});
    row_item(ACT_TAKE, 32'h0, 1'b0, 1'b1,
             out_item_t'{1'b1, 32'hFFFF_FFFF, 8'd0, 9'd2, 9'd1, 1'b0});
    row_item(ACT_TAKE, 32'h0, 1'b0, 1'b0, '0);
    // Take with nothing left untaken.
    row_item(ACT_TAKE, 32'h0, 1'b0, 1'b0, '0);
    row_item(ACT_RELEASE, 32'h0, 1'b0, 1'b0, '0);
    row_item(ACT_RESERVE, 32'h0, 1'b0, 1'b0, '0);
    // Push and a second reserve while a reservation is open.
    row_item(ACT_PUSH, 32'h5555_5555, 1'b1, 1'b0, '0);
    row_item(ACT_RESERVE, 32'h0, 1'b1, 1'b0, '0);
    // Shrinking the capacity makes the pending commit land on a full FIFO.
    row_cap(9'd1);
    row_item(ACT_COMMIT, 32'hA5A5_A5A5, 1'b0, 1'b0, '0);
    row_item(ACT_POP, 32'h0, 1'b0, 1'b0, '0);
    row_item(ACT_TAKE, 32'h0, 1'b0, 1'b1, '0);
    row_item(ACT_PUSH, 32'h1234_5678, 1'b0, 1'b0, '0);
    row_item(ACT_PUSH, 32'hCAFE_F00D, 1'b0, 1'b0, '0);
    row_item(ACT_PUSH, 32'h8765_4321, 1'b1, 1'b0, '0);
    row_item(ACT_TAKE, 32'h0, 1'b0, 1'b0, '0);
    // Overwriting push drops an item that was taken.
    row_item(ACT_PUSH, 32'hDEAD_BEEF, 1'b1, 1'b0, '0);
    row_item(ACT_RESERVE, 32'h0, 1'b0, 1'b0, '0);
    row_item(ACT_RESERVE, 32'h0, 1'b1, 1'b0, '0);
    row_item(ACT_COMMIT, 32'h0F0F_0F0F, 1'b0, 1'b0, '0);
    row_item(ACT_POP, 32'h0, 1'b0, 1'b0, '0);
    row_item(ACT_CLEAR, 32'h0, 1'b0, 1'b0, '0);
    row_cap(9'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    gap_pct   = 25;
    stall_pct = 25;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAP) write_capacity(directed_rows[i].cap);
      else send_item(directed_rows[i].item, directed_rows[i].has_exp, directed_rows[i].exp);
    end
    directed_items = items_sent;

    // Random phases, each under its own capacity and idling profile.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: next_cap = 9'd1;
        1: next_cap = 9'd256;
        2: next_cap = 9'd2;
        3: next_cap = 9'd0;
        4: next_cap = 9'd511;
        5: next_cap = 9'd257;
        default: begin
          push_w = $urandom_range(99);
          if (push_w < 60) next_cap = COUNT_W'($urandom_range(1, 8));
          else if (push_w < 90) next_cap = COUNT_W'($urandom_range(9, 256));
          else next_cap = COUNT_W'($urandom_range(257, 511));
        end
      endcase
      write_capacity(next_cap);
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 40;
      endcase
      // The second phase fills the whole store to reach full at the top capacity.
      push_w    = (ph == 1) ? 92 : $urandom_range(20, 70);
      phase_len = (ph == 1) ? FILL_PHASE_LEN : PHASE_LEN;
      repeat (phase_len) begin
        if (items_sent >= CALM_AFTER) calm = 1'b1;
        send_item(random_action(push_w), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (fifo_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d actions (%0d directed) under %0d capacity writes; %0d results checked.",
             items_sent, directed_items, cap_writes, results_checked);
    $display("%0d actions met a full FIFO, %0d were refused, %0d mismatches.",
             full_hits, refusals, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
